@@ rtl/core/ccra_pkg.sv @@
// Package for the CRC challenge-response authentication unit.
// Holds payload types, codes, CRC helpers, secret tables and the sequencer program.
// No dependencies.
package ccra_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam int SECRET_LEN_DEF = 16;
  localparam int TAB_IDX_W = 6;
  localparam int PC_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int TMO_W = 26;

  // Seconds from milliseconds: (ms >> 3) * DIV_MUL >> DIV_SHIFT is exact for 26-bit input.
  localparam logic [23:0] DIV_MUL = 24'd8589935;
  localparam int DIV_SHIFT = 30;
  localparam logic [31:0] TIMEOUT_RST = 32'd5000;

  localparam logic [PC_W-1:0] REQ_ENTRY = 6'd0;
  localparam logic [PC_W-1:0] RSP_ENTRY = 6'd13;

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_REQ  = 2'd1,
    OP_BEAT = 2'd2,
    OP_RSP  = 2'd3
  } ccra_op_t;

  typedef enum logic [1:0] {
    FK_NONE      = 2'd0,
    FK_CHALLENGE = 2'd1,
    FK_RESULT    = 2'd2
  } ccra_frame_t;

  typedef enum logic [1:0] {
    AR_OK        = 2'd0,
    AR_BAD_NONCE = 2'd1,
    AR_BAD_KEY   = 2'd2
  } ccra_result_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ccra_state_t;

  typedef enum logic [3:0] {
    SRC_NONE,
    SRC_NOW,
    SRC_BOARD,
    SRC_NONCE,
    SRC_KEY,
    SRC_LTYPE,
    SRC_FLAGS,
    SRC_KSEC,
    SRC_CSEC
  } ccra_src_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SAVE_KEY,
    ACT_FIN
  } ccra_act_t;

  typedef struct packed {
    ccra_op_t    op;
    logic [31:0] now_ms;
    logic [31:0] auth_code;
    logic [7:0]  license_type;
    logic [7:0]  flags;
    logic [7:0]  seq;
  } ccra_in_t;

  typedef struct packed {
    ccra_frame_t  frame_kind;
    logic [31:0]  challenge_board;
    logic [31:0]  challenge_nonce;
    logic         is_unlocked;
    ccra_result_t auth_result;
    logic [7:0]   fail_total;
    logic [7:0]   granted_type;
    logic [15:0]  timeout_seconds;
    logic [7:0]   seq_echo;
  } ccra_out_t;

  typedef struct packed {
    logic start;
    logic is_rsp;
  } ccra_eng_ctl_t;

  typedef struct packed {
    logic        done;
    logic [31:0] crc;
  } ccra_eng_sts_t;

  typedef struct packed {
    ccra_src_t src;
    logic [1:0] bsel;
    logic      init;
    logic      loop;
    ccra_act_t act;
  } ccra_cw_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic [7:0] key_secret(input logic [TAB_IDX_W-1:0] i);
    logic [7:0] b;
    case (i)
      6'd0:  b = 8'h31;
      6'd1:  b = 8'h39;
      6'd2:  b = 8'hC7;
      6'd3:  b = 8'h52;
      6'd4:  b = 8'hA6;
      6'd5:  b = 8'h0D;
      6'd6:  b = 8'h44;
      6'd7:  b = 8'hE8;
      6'd8:  b = 8'h92;
      6'd9:  b = 8'h16;
      6'd10: b = 8'h5A;
      6'd11: b = 8'hB3;
      6'd12: b = 8'hCF;
      6'd13: b = 8'h27;
      6'd14: b = 8'h68;
      6'd15: b = 8'h10;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] code_secret(input logic [TAB_IDX_W-1:0] i);
    logic [7:0] b;
    case (i)
      6'd0:  b = 8'hA4;
      6'd1:  b = 8'h2D;
      6'd2:  b = 8'h7E;
      6'd3:  b = 8'h19;
      6'd4:  b = 8'hC0;
      6'd5:  b = 8'h83;
      6'd6:  b = 8'h55;
      6'd7:  b = 8'h6B;
      6'd8:  b = 8'hE1;
      6'd9:  b = 8'h37;
      6'd10: b = 8'h90;
      6'd11: b = 8'h4C;
      6'd12: b = 8'h2A;
      6'd13: b = 8'hF5;
      6'd14: b = 8'h08;
      6'd15: b = 8'hD6;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic ccra_cw_t mk_cw(input ccra_src_t s, input logic [1:0] b,
                                     input logic i, input logic l, input ccra_act_t a);
    ccra_cw_t w;
    w.src  = s;
    w.bsel = b;
    w.init = i;
    w.loop = l;
    w.act  = a;
    return w;
  endfunction

  // Sequencer program: the request runs from REQ_ENTRY, the response from RSP_ENTRY.
  function automatic ccra_cw_t ccra_rom(input logic [PC_W-1:0] pc);
    ccra_cw_t w;
    unique case (pc)
      6'd0:  w = mk_cw(SRC_NOW,   2'd0, 1'b1, 1'b0, ACT_NONE);
      6'd1:  w = mk_cw(SRC_NOW,   2'd1, 1'b0, 1'b0, ACT_NONE);
      6'd2:  w = mk_cw(SRC_NOW,   2'd2, 1'b0, 1'b0, ACT_NONE);
      6'd3:  w = mk_cw(SRC_NOW,   2'd3, 1'b0, 1'b0, ACT_NONE);
      6'd4:  w = mk_cw(SRC_BOARD, 2'd0, 1'b0, 1'b0, ACT_NONE);
      6'd5:  w = mk_cw(SRC_BOARD, 2'd1, 1'b0, 1'b0, ACT_NONE);
      6'd6:  w = mk_cw(SRC_BOARD, 2'd2, 1'b0, 1'b0, ACT_NONE);
      6'd7:  w = mk_cw(SRC_BOARD, 2'd3, 1'b0, 1'b0, ACT_NONE);
      6'd8:  w = mk_cw(SRC_NONCE, 2'd0, 1'b0, 1'b0, ACT_NONE);
      6'd9:  w = mk_cw(SRC_NONCE, 2'd1, 1'b0, 1'b0, ACT_NONE);
      6'd10: w = mk_cw(SRC_NONCE, 2'd2, 1'b0, 1'b0, ACT_NONE);
      6'd11: w = mk_cw(SRC_NONCE, 2'd3, 1'b0, 1'b0, ACT_NONE);
      6'd12: w = mk_cw(SRC_NONE,  2'd0, 1'b0, 1'b0, ACT_FIN);
      6'd13: w = mk_cw(SRC_BOARD, 2'd0, 1'b1, 1'b0, ACT_NONE);
      6'd14: w = mk_cw(SRC_BOARD, 2'd1, 1'b0, 1'b0, ACT_NONE);
      6'd15: w = mk_cw(SRC_BOARD, 2'd2, 1'b0, 1'b0, ACT_NONE);
      6'd16: w = mk_cw(SRC_BOARD, 2'd3, 1'b0, 1'b0, ACT_NONE);
      6'd17: w = mk_cw(SRC_LTYPE, 2'd0, 1'b0, 1'b0, ACT_NONE);
      6'd18: w = mk_cw(SRC_KSEC,  2'd0, 1'b0, 1'b1, ACT_NONE);
      6'd19: w = mk_cw(SRC_NONE,  2'd0, 1'b0, 1'b0, ACT_SAVE_KEY);
      6'd20: w = mk_cw(SRC_BOARD, 2'd0, 1'b1, 1'b0, ACT_NONE);
      6'd21: w = mk_cw(SRC_BOARD, 2'd1, 1'b0, 1'b0, ACT_NONE);
      6'd22: w = mk_cw(SRC_BOARD, 2'd2, 1'b0, 1'b0, ACT_NONE);
      6'd23: w = mk_cw(SRC_BOARD, 2'd3, 1'b0, 1'b0, ACT_NONE);
      6'd24: w = mk_cw(SRC_NONCE, 2'd0, 1'b0, 1'b0, ACT_NONE);
      6'd25: w = mk_cw(SRC_NONCE, 2'd1, 1'b0, 1'b0, ACT_NONE);
      6'd26: w = mk_cw(SRC_NONCE, 2'd2, 1'b0, 1'b0, ACT_NONE);
      6'd27: w = mk_cw(SRC_NONCE, 2'd3, 1'b0, 1'b0, ACT_NONE);
      6'd28: w = mk_cw(SRC_KEY,   2'd0, 1'b0, 1'b0, ACT_NONE);
      6'd29: w = mk_cw(SRC_KEY,   2'd1, 1'b0, 1'b0, ACT_NONE);
      6'd30: w = mk_cw(SRC_KEY,   2'd2, 1'b0, 1'b0, ACT_NONE);
      6'd31: w = mk_cw(SRC_KEY,   2'd3, 1'b0, 1'b0, ACT_NONE);
      6'd32: w = mk_cw(SRC_LTYPE, 2'd0, 1'b0, 1'b0, ACT_NONE);
      6'd33: w = mk_cw(SRC_FLAGS, 2'd0, 1'b0, 1'b0, ACT_NONE);
      6'd34: w = mk_cw(SRC_CSEC,  2'd0, 1'b0, 1'b1, ACT_NONE);
      6'd35: w = mk_cw(SRC_NONE,  2'd0, 1'b0, 1'b0, ACT_FIN);
      default: w = mk_cw(SRC_NONE, 2'd0, 1'b0, 1'b0, ACT_FIN);
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/ccra_engine.sv @@
// Microcoded CRC-32 engine: step counter, loop counter and a bytewise CRC datapath.
// Depends on ccra_pkg for the program table, the CRC step and the secret tables.
module ccra_engine import ccra_pkg::*; #(
  parameter int SECRET_LEN = SECRET_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ccra_eng_ctl_t ctl,
  input  ccra_in_t      item,
  input  logic [31:0]   board,
  input  logic [31:0]   nonce,
  output ccra_eng_sts_t sts
);

  localparam int CNT_W = (SECRET_LEN > 1) ? $clog2(SECRET_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SECRET_LEN - 1);

  logic             run_r, run_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      key_r, key_nxt;
  ccra_cw_t         cw;
  logic [7:0]       feed_byte;
  logic [31:0]      crc_base;
  logic [4:0]       bofs;
  logic [TAB_IDX_W-1:0] tab_idx;

  assign cw      = ccra_rom(pc_r);
  assign bofs    = {cw.bsel, 3'b000};
  assign tab_idx = TAB_IDX_W'(cnt_r);
  assign crc_base = cw.init ? CRC_ONES : crc_r;

  always_comb begin
    case (cw.src)
      SRC_NOW:   feed_byte = item.now_ms[bofs +: 8];
      SRC_BOARD: feed_byte = board[bofs +: 8];
      SRC_NONCE: feed_byte = nonce[bofs +: 8];
      SRC_KEY:   feed_byte = key_r[bofs +: 8];
      SRC_LTYPE: feed_byte = item.license_type;
      SRC_FLAGS: feed_byte = item.flags;
      SRC_KSEC:  feed_byte = key_secret(tab_idx);
      SRC_CSEC:  feed_byte = code_secret(tab_idx);
      default:   feed_byte = 8'h00;
    endcase
  end

  always_comb begin
    run_nxt = run_r;
    pc_nxt  = pc_r;
    cnt_nxt = cnt_r;
    crc_nxt = crc_r;
    key_nxt = key_r;
    if (ctl.start) begin
      run_nxt = 1'b1;
      pc_nxt  = ctl.is_rsp ? RSP_ENTRY : REQ_ENTRY;
      cnt_nxt = '0;
    end else if (run_r) begin
      crc_nxt = (cw.src != SRC_NONE) ? crc_byte(crc_base, feed_byte) : crc_base;
      if (cw.act == ACT_SAVE_KEY) begin
        key_nxt = crc_r ^ CRC_ONES;
      end
      if (cw.act == ACT_FIN) begin
        run_nxt = 1'b0;
      end else if (cw.loop && (cnt_r != CNT_LAST)) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        cnt_nxt = '0;
        pc_nxt  = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pc_r  <= '0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    key_r <= key_nxt;
  end

  assign sts.done = run_r && (cw.act == ACT_FIN);
  assign sts.crc  = crc_r ^ CRC_ONES;

endmodule

@@ rtl/core/crc_challenge_response_auth.sv @@
// Top level of the CRC challenge-response authentication unit.
// Depends on ccra_pkg and instantiates ccra_engine.

// The unit works on one request at a time. Timeout ticks, heartbeats and responses that
// arrive with no nonce are settled in the cycle after acceptance. An auth request runs 13
// sequencer steps and an auth response a longer program with two loops over the secret
// tables, one CRC byte per cycle through the microcoded engine; in_stall is held while
// the engine runs. Each result then passes a pending register and the output register, so a
// new request can be accepted while the previous result still waits on out_stall.
module crc_challenge_response_auth import ccra_pkg::*; #(
  parameter int SECRET_LEN = SECRET_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ccra_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ccra_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  ccra_state_t   state_r, state_nxt;
  logic          unl_r, unl_nxt;
  logic [31:0]   nonce_r, nonce_nxt;
  logic [7:0]    fail_r, fail_nxt;
  logic [31:0]   beat_r, beat_nxt;
  logic [7:0]    lic_r, lic_nxt;
  logic [7:0]    flg_r, flg_nxt;
  logic [31:0]   board_r, board_nxt;
  logic [TMO_W-1:0] tmo_r, tmo_nxt;
  ccra_in_t      item_r, item_nxt;
  logic          pend_r, pend_nxt;
  ccra_out_t     pend_data_r, pend_data_nxt;
  logic          out_valid_r, out_valid_nxt;
  ccra_out_t     out_data_r, out_data_nxt;

  logic          in_accept;
  logic          out_free;
  logic          make_res;
  ccra_out_t     res;
  logic [7:0]    res_seq;
  logic [31:0]   elapsed;
  logic [31:0]   new_nonce;
  logic [46:0]   secs_prod;
  logic [16:0]   secs_q;
  logic [15:0]   secs;
  ccra_eng_ctl_t eng_ctl;
  ccra_eng_sts_t eng_sts;

  ccra_engine #(.SECRET_LEN(SECRET_LEN)) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (eng_ctl),
    .item  (item_r),
    .board (board_r),
    .nonce (nonce_r),
    .sts   (eng_sts)
  );

  assign in_stall  = (state_r != ST_IDLE) || pend_r;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign secs_prod = 47'(tmo_r[TMO_W-1:3]) * 47'(DIV_MUL);
  assign secs_q    = secs_prod[DIV_SHIFT +: 17];
  assign secs      = secs_q[16] ? 16'hFFFF : secs_q[15:0];
  assign elapsed   = in_data.now_ms - beat_r;
  assign new_nonce = (eng_sts.crc == 32'd0) ? 32'd1 : eng_sts.crc;

  always_comb begin
    state_nxt     = state_r;
    unl_nxt       = unl_r;
    nonce_nxt     = nonce_r;
    fail_nxt      = fail_r;
    beat_nxt      = beat_r;
    lic_nxt       = lic_r;
    flg_nxt       = flg_r;
    board_nxt     = board_r;
    tmo_nxt       = tmo_r;
    item_nxt      = item_r;
    pend_nxt      = pend_r;
    pend_data_nxt = pend_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    eng_ctl       = '0;
    make_res      = 1'b0;
    res           = '0;
    res_seq       = item_r.seq;
    out_free      = !out_valid_r || !out_stall;

    if (out_free) begin
      out_valid_nxt = pend_r;
      out_data_nxt  = pend_data_r;
      pend_nxt      = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BOARD_ID: board_nxt = cfg_data;
        CFG_TIMEOUT:  tmo_nxt   = cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          item_nxt = in_data;
          res_seq  = in_data.seq;
          unique case (in_data.op)
            OP_TICK: begin
              make_res = 1'b1;
              if (unl_r && (elapsed > {6'b0, tmo_r})) begin
                unl_nxt = 1'b0;
              end
            end
            OP_BEAT: begin
              make_res = 1'b1;
              if (unl_r) begin
                beat_nxt = in_data.now_ms;
              end
            end
            OP_REQ: begin
              eng_ctl.start  = 1'b1;
              eng_ctl.is_rsp = 1'b0;
              state_nxt      = ST_RUN;
            end
            OP_RSP: begin
              if (nonce_r == 32'd0) begin
                make_res        = 1'b1;
                unl_nxt         = 1'b0;
                fail_nxt        = fail_r + 1'b1;
                res.frame_kind  = FK_RESULT;
                res.auth_result = AR_BAD_NONCE;
              end else begin
                eng_ctl.start  = 1'b1;
                eng_ctl.is_rsp = 1'b1;
                state_nxt      = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (eng_sts.done) begin
          state_nxt = ST_IDLE;
          make_res  = 1'b1;
          if (item_r.op == OP_REQ) begin
            nonce_nxt           = new_nonce;
            unl_nxt             = 1'b0;
            res.frame_kind      = FK_CHALLENGE;
            res.challenge_board = board_r;
            res.challenge_nonce = new_nonce;
          end else if (item_r.auth_code == eng_sts.crc) begin
            unl_nxt         = 1'b1;
            beat_nxt        = item_r.now_ms;
            fail_nxt        = 8'd0;
            lic_nxt         = item_r.license_type;
            flg_nxt         = item_r.flags;
            res.frame_kind  = FK_RESULT;
            res.auth_result = AR_OK;
          end else begin
            unl_nxt         = 1'b0;
            fail_nxt        = fail_r + 1'b1;
            res.frame_kind  = FK_RESULT;
            res.auth_result = AR_BAD_KEY;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (make_res) begin
      pend_nxt                  = 1'b1;
      pend_data_nxt             = res;
      pend_data_nxt.is_unlocked = unl_nxt;
      if (res.frame_kind == FK_RESULT) begin
        pend_data_nxt.fail_total      = fail_nxt;
        pend_data_nxt.granted_type    = lic_nxt;
        pend_data_nxt.timeout_seconds = secs;
        pend_data_nxt.seq_echo        = res_seq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      unl_r       <= 1'b0;
      nonce_r     <= 32'd0;
      fail_r      <= 8'd0;
      beat_r      <= 32'd0;
      lic_r       <= 8'd0;
      flg_r       <= 8'd0;
      board_r     <= 32'd0;
      tmo_r       <= TIMEOUT_RST[TMO_W-1:0];
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      unl_r       <= unl_nxt;
      nonce_r     <= nonce_nxt;
      fail_r      <= fail_nxt;
      beat_r      <= beat_nxt;
      lic_r       <= lic_nxt;
      flg_r       <= flg_nxt;
      board_r     <= board_nxt;
      tmo_r       <= tmo_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    pend_data_r <= pend_data_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

@@ rtl/core/ccra_checker.sv @@
// Port-level checker for the CRC challenge-response authentication unit, with its bind.
// Depends on ccra_pkg and attaches to crc_challenge_response_auth.
module ccra_checker import ccra_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input ccra_in_t             in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input ccra_out_t            out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]          cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or dropped.");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.frame_kind == FK_NONE) |->
      (out_data.challenge_nonce == 32'd0) && (out_data.fail_total == 8'd0) &&
      (out_data.timeout_seconds == 16'd0) && (out_data.seq_echo == 8'd0))
    else $error("Result without frame carries nonzero fields.");

  a_challenge_locked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.frame_kind == FK_CHALLENGE) |->
      !out_data.is_unlocked && (out_data.challenge_nonce != 32'd0))
    else $error("Challenge left the session unlocked or sent a zero nonce.");

  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.frame_kind == FK_RESULT) |->
      (out_data.is_unlocked == (out_data.auth_result == AR_OK)) &&
      ((out_data.auth_result != AR_OK) || (out_data.fail_total == 8'd0)))
    else $error("Auth result disagrees with session state or fail count.");

endmodule

bind crc_challenge_response_auth ccra_checker u_ccra_checker (.*);
